@@ hw/rtl/button_gesture_detector_core_defines.svh @@
// Assertion macros used by the checker file of the gesture detector.
`ifndef BUTTON_GESTURE_DETECTOR_CORE_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define BGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BGD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/bgd_pkg.sv @@
`default_nettype none

package bgd_pkg;

    // Widths of the stream fields and configuration registers.
    localparam int unsigned TimeW    = 32;
    localparam int unsigned CfgW     = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned PhaseW   = 2;
    localparam int unsigned STdataW  = 40;
    localparam int unsigned MTdataW  = 8;

    typedef logic [PhaseW-1:0]  phase_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    // Phase codes of the debounce machine.
    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_DOWN = 2'd1;
    localparam phase_t PH_HELD = 2'd2;
    localparam phase_t PH_UP   = 2'd3;

    // Configuration register indexes.
    localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
    localparam cfg_idx_t REG_LONG     = 2'd1;
    localparam cfg_idx_t REG_DOUBLE   = 2'd2;

    // Register values after reset, in milliseconds.
    localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CfgW-1:0] LONG_RST     = 16'd3000;
    localparam logic [CfgW-1:0] DOUBLE_RST   = 16'd400;

endpackage

`default_nettype wire

@@ hw/rtl/button_gesture_detector_core.sv @@
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   pressed_level[0], now_time[32:1], zero pad to 40 bits
// m_axis    out  long_press_event[0], double_press_event[1], machine_state[3:2], pad
// cfg       in   cfg_index selects register, cfg_wdata is its 16-bit value
//
// One result beat per input beat; an input beat waits in the input register
// and its result is written to the output register when the output is free.
// Sustained rate is one beat per cycle while m_tready is high (combinational update).
// Reset (synchronous, aresetn low) clears the machine and restores defaults.
// A stalled m_tready holds the result; the input register still takes one beat.
`default_nettype none

module button_gesture_detector_core
    import bgd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input samples.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [STdataW-1:0]  s_tdata,   // pressed_level, now_time
    // Gesture results.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [MTdataW-1:0]       m_tdata,   // long_press_event, double_press_event,
                                                // machine_state
    // Configuration writes.
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgW-1:0]     cfg_wdata
);

    // Input register.
    logic             in_vld_reg;
    logic             in_pressed_reg;
    logic [TimeW-1:0] in_now_reg;

    // Output register.
    logic             out_vld_reg;
    logic             out_long_reg;
    logic             out_dbl_reg;
    phase_t           out_phase_reg;

    // Configuration registers.
    logic [CfgW-1:0]  debounce_reg;
    logic [CfgW-1:0]  long_time_reg;
    logic [CfgW-1:0]  window_reg;

    // Gesture state.
    phase_t           phase_reg,          phase_next;
    logic [TimeW-1:0] entry_time_reg,     entry_time_next;
    logic [TimeW-1:0] press_start_reg,    press_start_next;
    logic             long_fired_reg,     long_fired_next;
    logic             suppress_reg,       suppress_next;
    logic             click_pend_reg,     click_pend_next;
    logic [TimeW-1:0] click_rel_reg,      click_rel_next;
    logic             long_ev_next;
    logic             dbl_ev_next;

    logic             advance;
    logic [TimeW-1:0] since_entry;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_click;
    logic             debounce_done;
    logic             long_due;
    logic             in_window;

    // A beat moves from the input register to the output register when the
    // output is empty or drained this cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_phase_reg, out_dbl_reg, out_long_reg};

    // Elapsed times wrap modulo 2^32.
    assign since_entry   = in_now_reg - entry_time_reg;
    assign since_press   = in_now_reg - press_start_reg;
    assign since_click   = in_now_reg - click_rel_reg;
    assign debounce_done = since_entry >= TimeW'(debounce_reg);
    assign long_due      = since_press >= TimeW'(long_time_reg);
    assign in_window     = since_click <= TimeW'(window_reg);

    // Next state of the debounce and gesture machine.
    always_comb begin
        phase_next       = phase_reg;
        entry_time_next  = entry_time_reg;
        press_start_next = press_start_reg;
        long_fired_next  = long_fired_reg;
        suppress_next    = suppress_reg;
        click_pend_next  = click_pend_reg;
        click_rel_next   = click_rel_reg;
        long_ev_next     = 1'b0;
        dbl_ev_next      = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (in_pressed_reg) begin
                    phase_next      = PH_DOWN;
                    entry_time_next = in_now_reg;
                end else if (click_pend_reg && !in_window) begin
                    click_pend_next = 1'b0;
                end
            end
            PH_DOWN: begin
                if (!in_pressed_reg) begin
                    phase_next = PH_IDLE;
                end else if (debounce_done) begin
                    press_start_next = in_now_reg;
                    long_fired_next  = 1'b0;
                    suppress_next    = 1'b0;
                    // Second press of a double confirmed inside the window.
                    if (click_pend_reg && in_window) begin
                        click_pend_next = 1'b0;
                        suppress_next   = 1'b1;
                        dbl_ev_next     = 1'b1;
                    end
                    phase_next = PH_HELD;
                end
            end
            PH_HELD: begin
                if (!in_pressed_reg) begin
                    phase_next      = PH_UP;
                    entry_time_next = in_now_reg;
                end else if (!long_fired_reg && !suppress_reg && long_due) begin
                    long_fired_next = 1'b1;
                    long_ev_next    = 1'b1;
                end
            end
            PH_UP: begin
                if (in_pressed_reg) begin
                    phase_next = PH_HELD;
                end else if (debounce_done) begin
                    // Only a plain short click arms the double-press window.
                    if (long_fired_reg) begin
                        click_pend_next = 1'b0;
                    end else if (suppress_reg) begin
                        suppress_next   = 1'b0;
                        click_pend_next = 1'b0;
                    end else begin
                        click_pend_next = 1'b1;
                        click_rel_next  = in_now_reg;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Handshake, configuration and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            debounce_reg    <= DEBOUNCE_RST;
            long_time_reg   <= LONG_RST;
            window_reg      <= DOUBLE_RST;
            phase_reg       <= PH_IDLE;
            entry_time_reg  <= '0;
            press_start_reg <= '0;
            long_fired_reg  <= 1'b0;
            suppress_reg    <= 1'b0;
            click_pend_reg  <= 1'b0;
            click_rel_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end

            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DEBOUNCE: debounce_reg  <= cfg_wdata;
                    REG_LONG:     long_time_reg <= cfg_wdata;
                    REG_DOUBLE:   window_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (advance) begin
                phase_reg       <= phase_next;
                entry_time_reg  <= entry_time_next;
                press_start_reg <= press_start_next;
                long_fired_reg  <= long_fired_next;
                suppress_reg    <= suppress_next;
                click_pend_reg  <= click_pend_next;
                click_rel_reg   <= click_rel_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pressed_reg <= s_tdata[0];
            in_now_reg     <= s_tdata[TimeW:1];
        end
        if (advance) begin
            out_long_reg  <= long_ev_next;
            out_dbl_reg   <= dbl_ev_next;
            out_phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bgd_checker.sv @@
`default_nettype none
`include "button_gesture_detector_core_defines.svh"

module bgd_checker
    import bgd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [MTdataW-1:0]  m_tdata
);

    // A result beat that is not taken stays put.
    `BGD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // No result is offered right after a reset edge.
    `BGD_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // A long press is only reported while the button is held.
    `BGD_ASSERT(a_long_held, m_tvalid && m_tdata[0] |-> m_tdata[3:2] == PH_HELD, "long press outside held phase")

    // A double press is only reported on the confirmation into the held phase.
    `BGD_ASSERT(a_dbl_held, m_tvalid && m_tdata[1] |-> m_tdata[3:2] == PH_HELD, "double press outside held phase")

    // The two gestures never share one beat.
    `BGD_ASSERT(a_one_event, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "both gesture events in one beat")

endmodule

bind button_gesture_detector_core bgd_checker u_bgd_checker (.*);

`default_nettype wire
